// ===== rtl/core/bcc_pkg.sv =====
// Shared types and codes for the checked binomial coefficient block.
// No dependencies; imported by bcc_muldiv and binomial_coefficient_checked.
`default_nettype none
package bcc_pkg;

  localparam int unsigned ACC_W = 64;
  localparam int unsigned OPD_W = 31;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic start;
  } md_ctl_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } md_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/bcc_muldiv.sv =====
// Bit-serial multiply of the running product by a factor, then (if no overflow)
// exact restoring division by a divisor, one bit per cycle. Depends on bcc_pkg.
`default_nettype none
module bcc_muldiv import bcc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire md_ctl_t            ctl,
  input  wire logic [ACC_W-1:0]   acc_in,
  input  wire logic [OPD_W-1:0]   factor_in,
  input  wire logic [OPD_W-1:0]   divisor_in,
  output md_rsp_t                 rsp,
  output logic [ACC_W-1:0]        result
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_MUL  = 2'd1;
  localparam logic [1:0] M_DIV  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [ACC_W-1:0]  mcand_r, mcand_nxt;
  logic [ACC_W-1:0]  hi_r, hi_nxt;
  logic [31:0]       lo_r, lo_nxt;
  logic [31:0]       rem_r, rem_nxt;
  logic [OPD_W-1:0]  div_r, div_nxt;
  md_rsp_t           rsp_r, rsp_nxt;
  logic [ACC_W:0]    sum;
  logic [32:0]       shrem;
  logic              ge;

  always_comb begin
    sum   = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : '0);
    shrem = {rem_r, hi_r[ACC_W-1]};
    ge    = shrem >= {2'b00, div_r};
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mcand_nxt = mcand_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    rsp_nxt   = '0;
    unique case (state_r)
      M_IDLE: begin
        if (ctl.start) begin
          mcand_nxt = acc_in;
          lo_nxt    = {1'b0, factor_in};
          div_nxt   = divisor_in;
          hi_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = M_MUL;
        end
      end
      M_MUL: begin
        hi_nxt  = sum[ACC_W:1];
        lo_nxt  = {sum[0], lo_r[31:1]};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          cnt_nxt = '0;
          // The product's top 32 bits must be clear for it to fit in 64 bits.
          if (sum[ACC_W:33] != '0) begin
            rsp_nxt   = '{done: 1'b1, ovf: 1'b1};
            state_nxt = M_IDLE;
          end else begin
            hi_nxt    = {sum[32:1], sum[0], lo_r[31:1]};
            rem_nxt   = '0;
            state_nxt = M_DIV;
          end
        end
      end
      M_DIV: begin
        // The dividend shifts out at the top while quotient bits enter below.
        rem_nxt = ge ? 32'(shrem - {2'b00, div_r}) : shrem[31:0];
        hi_nxt  = {hi_r[ACC_W-2:0], ge};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          rsp_nxt   = '{done: 1'b1, ovf: 1'b0};
          state_nxt = M_IDLE;
        end
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      rsp_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rsp_r   <= rsp_nxt;
      cnt_r   <= cnt_nxt;
    end
    mcand_r <= mcand_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
  end

  assign rsp    = rsp_r;
  assign result = hi_r;

endmodule
`default_nettype wire

// ===== rtl/core/binomial_coefficient_checked.sv =====
// Checked binomial coefficient C(n, k) with a status code.
// Depends on bcc_pkg and bcc_muldiv.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_stall   in_n_total, in_k_chosen
//   out_     output     out_valid / out_stall out_coefficient, out_status
//
// One pair is worked on at a time. Each round of the product loop runs 32
// multiply steps and then 64 divide steps in the serial unit; a pair takes
// min(k, n-k) rounds, or fewer when the overflow check stops it early.
// Rejected arguments go from the check state straight to the output state.
// Reset is synchronous and leaves the block idle. A held result in the output
// register does not stop the next pair being taken.
`default_nettype none
module binomial_coefficient_checked import bcc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_n_total,
  input  wire logic [31:0] in_k_chosen,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_coefficient,
  output logic [1:0]       out_status
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_LOOP  = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [31:0]       n_r, n_nxt;
  logic [31:0]       k_r, k_nxt;
  logic [OPD_W-1:0]  kk_r, kk_nxt;
  logic [OPD_W-1:0]  i_r, i_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [31:0]       res_coef_r, res_coef_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_coef_r, out_coef_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [OPD_W-1:0]  n_minus_k;
  logic              bad_args;
  md_ctl_t           md_ctl;
  md_rsp_t           md_rsp;
  logic [ACC_W-1:0]  md_result;
  logic              in_xfer;

  assign in_xfer   = in_valid && !in_stall;
  assign bad_args  = n_r[31] || k_r[31] || ($signed(k_r) > $signed(n_r));
  assign n_minus_k = n_r[OPD_W-1:0] - k_r[OPD_W-1:0];

  bcc_muldiv u_muldiv (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (md_ctl),
    .acc_in     (acc_r),
    .factor_in  (n_r[OPD_W-1:0] - i_r),
    .divisor_in (i_r + 31'd1),
    .rsp        (md_rsp),
    .result     (md_result)
  );

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    kk_nxt         = kk_r;
    i_nxt          = i_r;
    acc_nxt        = acc_r;
    res_coef_nxt   = res_coef_r;
    res_status_nxt = res_status_r;
    md_ctl         = '0;
    out_valid_nxt  = out_valid_r && out_stall;
    out_coef_nxt   = out_coef_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          n_nxt     = in_n_total;
          k_nxt     = in_k_chosen;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        i_nxt   = '0;
        acc_nxt = 64'd1;
        if (bad_args) begin
          res_coef_nxt   = '0;
          res_status_nxt = ST_INVALID;
          state_nxt      = S_OUT;
        end else begin
          kk_nxt    = (k_r[OPD_W-1:0] > n_minus_k) ? n_minus_k : k_r[OPD_W-1:0];
          state_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        if (i_r == kk_r) begin
          if (acc_r[ACC_W-1:32] != '0) begin
            res_coef_nxt   = '0;
            res_status_nxt = ST_OVERFLOW;
          end else begin
            res_coef_nxt   = acc_r[31:0];
            res_status_nxt = ST_OK;
          end
          state_nxt = S_OUT;
        end else begin
          md_ctl.start = 1'b1;
          state_nxt    = S_WAIT;
        end
      end
      S_WAIT: begin
        if (md_rsp.done) begin
          if (md_rsp.ovf) begin
            res_coef_nxt   = '0;
            res_status_nxt = ST_OVERFLOW;
            state_nxt      = S_OUT;
          end else begin
            acc_nxt   = md_result;
            i_nxt     = i_r + 31'd1;
            state_nxt = S_LOOP;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_coef_nxt   = res_coef_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r          <= n_nxt;
    k_r          <= k_nxt;
    kk_r         <= kk_nxt;
    i_r          <= i_nxt;
    acc_r        <= acc_nxt;
    res_coef_r   <= res_coef_nxt;
    res_status_r <= res_status_nxt;
    out_coef_r   <= out_coef_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_coefficient = out_coef_r;
  assign out_status      = out_status_r;

  // A result is only reported complete by the serial unit while it is awaited.
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    md_rsp.done |-> (state_r == S_WAIT))
    else $error("serial unit finished outside a round");

  // A failed status always carries a zero coefficient.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_coefficient == '0))
    else $error("error result with non-zero coefficient");

  // A new pair is only taken when the previous one has gone to the output.
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_CHECK))
    else $error("transfer accepted while busy");

  // The round counter never passes the reduced k.
  a_i_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOP || state_r == S_WAIT) |-> (i_r <= kk_r))
    else $error("round counter beyond k");

endmodule
`default_nettype wire
